/* src/spr_pkg.sv */
// ----------------------------------------------------------------------------
// spr_pkg
// shared types and constants for the shortest path router
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam int MAX_NODES   = 64;
	localparam int MAX_EDGES   = 256;
	localparam int WEIGHT_BITS = 16;
	localparam int NODE_BITS   = $clog2(MAX_NODES);
	localparam int SLOT_BITS   = $clog2(MAX_EDGES);
	localparam int DIST_BITS   = 22;
	localparam int NCNT_BITS   = 7;
	localparam int ECNT_BITS   = 9;
	localparam int ADDR_BITS   = 3;

	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

	localparam logic [ADDR_BITS-1:0] REG_NODE_COUNT = 3'd0;
	localparam logic [ADDR_BITS-1:0] REG_EDGE_COUNT = 3'd4;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_ROUTE = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [7:0] edge_slot;
		logic [5:0] edge_end_a;
		logic [5:0] edge_end_b;
		logic [15:0] edge_weight;
		logic [5:0] route_start;
		logic [5:0] route_end;
	} in_item_t;

	typedef struct packed {
		logic [5:0] path_node;
		logic       found;
		logic       last;
	} out_item_t;

endpackage

/* src/shortest_path_router_unit.sv */
// ----------------------------------------------------------------------------
// shortest_path_router_unit
// Dijkstra router with edge table, distance and predecessor memories
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready, in_item): mode 0 writes one edge table
//   entry and gives no result; mode 1 runs a route query.
//   out channel (out_valid/out_ready, out_item): one transaction per path
//   node, start first, last set on the final one; an unreachable or off
//   graph query gives one transaction with found clear.
//   node_count and edge_count must be written over the APB port only
//   while idle; the block itself does not enforce this. a query first
//   initializes all 64 distance entries, then each settled node costs a
//   minimum scan over node_count entries and an edge scan with one
//   read-modify-write of the single port distance memory per edge, then
//   the path walk. one query is worked on at a time; in_ready is low until
//   its last result is taken. a stalled receiver holds the output register
//   and the emission. reset clears control state and out_valid, sets
//   node_count to 64 and edge_count to 0; no memory clearing pass.
// ----------------------------------------------------------------------------
module shortest_path_router_unit
	import spr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_INIT  = 13'b0000000000010,
		ST_MINRD = 13'b0000000000100,
		ST_MIN   = 13'b0000000001000,
		ST_PICK  = 13'b0000000010000,
		ST_ERD   = 13'b0000000100000,
		ST_EDIST = 13'b0000001000000,
		ST_EUPD  = 13'b0000010000000,
		ST_WALK  = 13'b0000100000000,
		ST_WRD   = 13'b0001000000000,
		ST_EMIT  = 13'b0010000000000,
		ST_FAIL  = 13'b0100000000000,
		ST_DONE  = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [NCNT_BITS-1:0] node_count_q;
	logic [ECNT_BITS-1:0] edge_count_q;
	logic [NCNT_BITS:0]   nodes_eff;
	logic [ECNT_BITS:0]   edges_eff;

	// memories
	logic [NODE_BITS-1:0]   ea_mem [MAX_EDGES];
	logic [NODE_BITS-1:0]   eb_mem [MAX_EDGES];
	logic [WEIGHT_BITS-1:0] ew_mem [MAX_EDGES];
	logic [DIST_BITS-1:0]   dist_mem [MAX_NODES];
	logic [NODE_BITS-1:0]   pred_mem [MAX_NODES];
	logic [NODE_BITS-1:0]   path_mem [MAX_NODES];

	logic [MAX_NODES-1:0] reached_q, settled_q;

	logic [NODE_BITS-1:0] start_q, end_q, cur_q, best_q, nb_q, at_q;
	logic                 have_q;
	logic [DIST_BITS-1:0] best_d_q, cur_d_q, cand_q;
	logic [NODE_BITS:0]   idx_q;      // node scan index
	logic [ECNT_BITS:0]   eidx_q;     // edge scan index
	logic [NODE_BITS:0]   len_q, ptr_q;
	logic                 ok_q;

	logic [NODE_BITS-1:0]   ea_rd, eb_rd, pred_rd;
	logic [WEIGHT_BITS-1:0] ew_rd;
	logic [DIST_BITS-1:0]   dist_rd;
	logic [NODE_BITS-1:0]   dist_addr, pred_addr;
	logic [DIST_BITS-1:0]   dist_wdata;
	logic                   dist_we;

	out_item_t out_q;
	logic      out_valid_q;
	logic      out_take;

	assign nodes_eff = (node_count_q > NCNT_BITS'(MAX_NODES)) ?
		(NCNT_BITS+1)'(MAX_NODES) : {1'b0, node_count_q};
	assign edges_eff = (edge_count_q > ECNT_BITS'(MAX_EDGES)) ?
		(ECNT_BITS+1)'(MAX_EDGES) : {1'b0, edge_count_q};

	// apb
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr)
			REG_NODE_COUNT: prdata = 32'(node_count_q);
			REG_EDGE_COUNT: prdata = 32'(edge_count_q);
			default:        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NCNT_BITS'(MAX_NODES);
			edge_count_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr == REG_NODE_COUNT) node_count_q <= pwdata[NCNT_BITS-1:0];
			if (paddr == REG_EDGE_COUNT) edge_count_q <= pwdata[ECNT_BITS-1:0];
		end
	end

	// edge table
	logic edge_we;
	assign in_ready = (state_q == ST_IDLE);
	assign edge_we  = in_valid && in_ready && (in_item.mode == MODE_LOAD);

	always_ff @(posedge clk) begin
		if (edge_we) begin
			ea_mem[in_item.edge_slot[SLOT_BITS-1:0]] <= in_item.edge_end_a;
			eb_mem[in_item.edge_slot[SLOT_BITS-1:0]] <= in_item.edge_end_b;
			ew_mem[in_item.edge_slot[SLOT_BITS-1:0]] <= in_item.edge_weight;
		end
		ea_rd <= ea_mem[eidx_q[SLOT_BITS-1:0]];
		eb_rd <= eb_mem[eidx_q[SLOT_BITS-1:0]];
		ew_rd <= ew_mem[eidx_q[SLOT_BITS-1:0]];
	end

	// edge match on registered table read
	logic ea_ok, match_a, match_b;
	assign ea_ok   = ({1'b0, ea_rd} < nodes_eff) && ({1'b0, eb_rd} < nodes_eff);
	assign match_a = (ea_rd == cur_q);
	assign match_b = (eb_rd == cur_q);

	// distance memory, single port
	always_comb begin
		dist_addr  = idx_q[NODE_BITS-1:0];
		dist_we    = 1'b0;
		dist_wdata = DIST_MAX;
		unique case (state_q)
			ST_INIT: dist_we = 1'b1;
			// neighbor of the current edge, read ahead of the update
			ST_EDIST: dist_addr = match_a ? eb_rd : ea_rd;
			ST_EUPD: dist_addr = nb_q;
			default: ;
		endcase
		if (state_q == ST_EUPD && ok_q &&
			(!reached_q[nb_q] || cand_q < dist_rd)) begin
			dist_we    = 1'b1;
			dist_wdata = cand_q;
		end
	end

	always_ff @(posedge clk) begin
		if (dist_we) dist_mem[dist_addr] <= dist_wdata;
		dist_rd <= dist_mem[dist_addr];
	end

	assign pred_addr = at_q;
	always_ff @(posedge clk) begin
		if (dist_we && state_q == ST_EUPD) pred_mem[nb_q] <= cur_q;
		pred_rd <= pred_mem[pred_addr];
		if (state_q == ST_WALK) path_mem[len_q[NODE_BITS-1:0]] <= at_q;
	end

	// candidate with saturation
	logic [DIST_BITS:0] sum;
	assign sum = {1'b0, cur_d_q} + (DIST_BITS+1)'(ew_rd);

	logic walk_stop;
	assign walk_stop = (at_q == start_q) || ((len_q + 1'b1) >= nodes_eff);

	// output register load
	assign out_take = (state_q == ST_EMIT || state_q == ST_FAIL) &&
		(!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			reached_q   <= '0;
			settled_q   <= '0;
			idx_q       <= '0;
			eidx_q      <= '0;
			have_q      <= 1'b0;
			ok_q        <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_item.mode == MODE_ROUTE) begin
						start_q <= in_item.route_start;
						end_q   <= in_item.route_end;
						if ({1'b0, in_item.route_start} >= nodes_eff ||
							{1'b0, in_item.route_end} >= nodes_eff) begin
							state_q <= ST_FAIL;
						end else begin
							idx_q     <= '0;
							reached_q <= '0;
							settled_q <= '0;
							state_q   <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					if (idx_q + 1'b1 == (NODE_BITS+1)'(MAX_NODES)) begin
						reached_q[start_q] <= 1'b1;
						state_q <= ST_PICK; // start has distance 0 and is the only reached node
						cur_q   <= start_q;
						cur_d_q <= '0;
						have_q  <= 1'b1;
						best_q  <= start_q;
						best_d_q <= '0;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_MINRD: begin
					idx_q  <= idx_q + 1'b1;
					have_q <= 1'b0;
					state_q <= ST_MIN;
				end
				ST_MIN: begin
					// dist_rd holds entry idx_q-1
					if (reached_q[idx_q[NODE_BITS-1:0] - 1'b1] &&
						!settled_q[idx_q[NODE_BITS-1:0] - 1'b1] &&
						(!have_q || dist_rd < best_d_q)) begin
						have_q   <= 1'b1;
						best_q   <= idx_q[NODE_BITS-1:0] - 1'b1;
						best_d_q <= dist_rd;
					end
					if (idx_q >= nodes_eff[NODE_BITS:0]) state_q <= ST_PICK;
					else idx_q <= idx_q + 1'b1;
				end
				ST_PICK: begin
					if (!have_q || !reached_q[end_q] && 1'b0) begin
						state_q <= ST_FAIL;
					end else if (best_q == end_q) begin
						at_q  <= end_q;
						len_q <= '0;
						state_q <= ST_WALK;
					end else begin
						settled_q[best_q] <= 1'b1;
						cur_q   <= best_q;
						cur_d_q <= best_d_q;
						eidx_q  <= '0;
						state_q <= (edges_eff == '0) ? ST_MINRD : ST_ERD;
						if (edges_eff == '0) idx_q <= '0;
					end
				end
				ST_ERD: begin
					// table read for eidx_q in flight
					state_q <= ST_EDIST;
				end
				ST_EDIST: begin
					nb_q   <= match_a ? eb_rd : ea_rd;
					ok_q   <= ea_ok && (match_a || match_b) &&
						!settled_q[match_a ? eb_rd : ea_rd];
					cand_q <= sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
					state_q <= ST_EUPD;
				end
				ST_EUPD: begin
					// dist_rd holds nb_q distance
					if (ok_q && (!reached_q[nb_q] || cand_q < dist_rd))
						reached_q[nb_q] <= 1'b1;
					if (eidx_q + 1'b1 >= edges_eff) begin
						idx_q   <= '0;
						state_q <= ST_MINRD;
					end else begin
						eidx_q  <= eidx_q + 1'b1;
						state_q <= ST_ERD;
					end
				end
				ST_WALK: begin
					len_q <= len_q + 1'b1;
					if (walk_stop) begin
						ptr_q   <= len_q;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_WRD;
					end
				end
				ST_WRD: begin
					at_q    <= pred_rd;
					state_q <= ST_WALK;
				end
				ST_EMIT: begin
					if (out_take) begin
						out_q.path_node <= path_mem[ptr_q[NODE_BITS-1:0]];
						out_q.found     <= 1'b1;
						out_q.last      <= (ptr_q == '0);
						if (ptr_q == '0) state_q <= ST_DONE;
						else ptr_q <= ptr_q - 1'b1;
					end
				end
				ST_FAIL: begin
					if (out_take) begin
						out_q.path_node <= '0;
						out_q.found     <= 1'b0;
						out_q.last      <= 1'b1;
						state_q         <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_item.last)
		else $error("input taken while a path is still pending");
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.found |-> out_item.last)
		else $error("not found result without last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result dropped under stall");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for shortest_path_router_unit: builds edge tables over
// the input channel, changes node and edge counts over APB between phases,
// fires route queries and compares every path transaction with a built-in
// Dijkstra predictor, under random gaps, stalls and one long output hold-off
// ----------------------------------------------------------------------------
module tb_top;
	import spr_pkg::*;

	class route_scoreboard;
		int unsigned node_cnt = 64;
		int unsigned edge_cnt = 0;
		int unsigned end_a[MAX_EDGES];
		int unsigned end_b[MAX_EDGES];
		int unsigned weight[MAX_EDGES];
		bit          written[MAX_EDGES];
		out_item_t   path_q[$];
		int          errors;
		int          checked;
		int          n_loads;
		int          n_routes;

		function int unsigned loaded_prefix();
			int unsigned k;
			k = 0;
			while (k < MAX_EDGES && written[k]) k++;
			return k;
		endfunction

		function void add_hop(int unsigned node, bit fnd, bit lst);
			out_item_t o;
			o.path_node = node[5:0];
			o.found     = fnd;
			o.last      = lst;
			path_q = {path_q, o};
		endfunction

		function void note_request(in_item_t it);
			int unsigned n, m, s, t, cur, nb, nd, len, at, i, e;
			int unsigned cost[MAX_NODES];
			int unsigned pred[MAX_NODES];
			int unsigned hops[MAX_NODES];
			bit          seen[MAX_NODES];
			bit          done[MAX_NODES];
			bit          have;
			if (it.mode == MODE_LOAD) begin
				end_a[it.edge_slot]   = it.edge_end_a;
				end_b[it.edge_slot]   = it.edge_end_b;
				weight[it.edge_slot]  = it.edge_weight;
				written[it.edge_slot] = 1'b1;
				n_loads++;
				return;
			end
			n_routes++;
			n = node_cnt > MAX_NODES ? MAX_NODES : node_cnt;
			m = edge_cnt > MAX_EDGES ? MAX_EDGES : edge_cnt;
			s = it.route_start;
			t = it.route_end;
			if (s >= n || t >= n) begin
				add_hop(0, 1'b0, 1'b1);
				return;
			end
			for (i = 0; i < MAX_NODES; i++) begin
				cost[i] = DIST_MAX;
				seen[i] = 1'b0;
				done[i] = 1'b0;
				pred[i] = 0;
			end
			cost[s] = 0;
			seen[s] = 1'b1;
			forever begin
				have = 1'b0;
				cur  = 0;
				// minimum scan, lowest index wins a tie
				for (i = 0; i < n; i++)
					if (seen[i] && !done[i] && (!have || cost[i] < cost[cur])) begin
						cur  = i;
						have = 1'b1;
					end
				if (!have || cur == t) break;
				done[cur] = 1'b1;
				for (e = 0; e < m; e++) begin
					if (end_a[e] >= n || end_b[e] >= n) continue;
					if (end_a[e] == cur) nb = end_b[e];
					else if (end_b[e] == cur) nb = end_a[e];
					else continue;
					if (done[nb]) continue;
					nd = cost[cur] + weight[e];
					if (nd > DIST_MAX) nd = DIST_MAX;
					if (!seen[nb] || nd < cost[nb]) begin
						cost[nb] = nd;
						seen[nb] = 1'b1;
						pred[nb] = cur;
					end
				end
			end
			if (!seen[t]) begin
				add_hop(0, 1'b0, 1'b1);
				return;
			end
			len = 0;
			at  = t;
			while (len < n) begin
				hops[len] = at;
				len++;
				if (at == s) break;
				at = pred[at];
			end
			for (i = 0; i < len; i++)
				add_hop(hops[len-1-i], 1'b1, i == len - 1);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (path_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected transaction node=%0d found=%0b last=%0b",
						$realtime, got.path_node, got.found, got.last);
				return;
			end
			want = path_q.pop_front();
			checked++;
			if (got.path_node !== want.path_node || got.found !== want.found ||
				got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display({"%0t: mismatch exp node=%0d found=%0b last=%0b",
						" got node=%0d found=%0b last=%0b"},
						$realtime, want.path_node, want.found, want.last,
						got.path_node, got.found, got.last);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_item;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	route_scoreboard sb;
	int              stall_pct;
	int              hold_req;
	int              gap_pct;

	shortest_path_router_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	initial begin
		#50ms;
		$display("timeout");
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r >= gap_pct) return 0;
		if (r < gap_pct / 8) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// valid stays high across back-to-back transactions
	task automatic push_item(input in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_item  <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_request(it);
	endtask

	task automatic push_load(input int unsigned slot, a, b, w);
		in_item_t    it;
		logic [63:0] r;
		r              = {$urandom, $urandom};
		it             = r[$bits(in_item_t)-1:0];
		it.mode        = MODE_LOAD;
		it.edge_slot   = slot[7:0];
		it.edge_end_a  = a[5:0];
		it.edge_end_b  = b[5:0];
		it.edge_weight = w[15:0];
		push_item(it);
	endtask

	task automatic push_route(input int unsigned s, t);
		in_item_t    it;
		logic [63:0] r;
		r              = {$urandom, $urandom};
		it             = r[$bits(in_item_t)-1:0];
		it.mode        = MODE_ROUTE;
		it.route_start = s[5:0];
		it.route_end   = t[5:0];
		push_item(it);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.path_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input int unsigned val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == REG_NODE_COUNT) sb.node_cnt = val & 32'h7f;
		else sb.edge_cnt = val & 32'h1ff;
	endtask

	function automatic int unsigned rand_weight();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 3);
			1: return $urandom_range(0, 65535);
			2: return 65535 - $urandom_range(0, 3);
			default: return $urandom_range(0, 40);
		endcase
	endfunction

	function automatic int unsigned rand_node(input int unsigned span);
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
		return $urandom_range(0, span > 63 ? 63 : span);
	endfunction

	// receiver: random stalls plus an occasional long hold-off
	initial begin
		int stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) sb.check_result(out_item);
			if (hold_req > 0) begin
				// hold-off counts only while a result is waiting
				if (out_valid) hold_req--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < stall_pct)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 3);
			end
		end
	end

	initial begin
		int unsigned nc_set[7];
		int unsigned ec_set[7];
		int unsigned span, want_edges, p, k;
		nc_set    = '{8, 1, 0, 64, 100, 16, 64};
		ec_set    = '{16, 8, 12, 40, 30, 48, 0};
		sb        = new;
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		out_ready = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		stall_pct = 20;
		gap_pct   = 40;
		hold_req  = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table under reset counts: trivial, unreachable
		push_route(0, 0);
		push_route(63, 63);
		push_route(0, 63);
		push_route(5, 2);
		// small graph with ties, a self loop, parallel and off-graph edges
		push_load(0, 0, 1, 1);
		push_load(1, 1, 2, 1);
		push_load(2, 0, 2, 2);
		push_load(3, 2, 3, 0);
		push_load(4, 3, 4, 65535);
		push_load(5, 2, 4, 5);
		push_load(6, 4, 5, 3);
		push_load(7, 5, 6, 3);
		push_load(8, 4, 6, 6);
		push_load(9, 6, 7, 1);
		push_load(10, 7, 63, 0);
		push_load(11, 3, 3, 4);
		push_load(12, 1, 0, 7);
		push_load(13, 5, 5, 0);
		push_load(14, 6, 2, 100);
		push_load(15, 8, 7, 0);
		push_load(255, 63, 0, 65535);
		settle();
		apb_write(REG_NODE_COUNT, 8);
		apb_write(REG_EDGE_COUNT, 16);
		push_route(0, 7);
		push_route(7, 0);
		push_route(3, 3);
		push_route(0, 8);
		push_route(9, 0);
		push_route(63, 0);
		settle();

		for (p = 0; p < 7; p++) begin
			span       = nc_set[p] > 64 ? 64 : nc_set[p];
			want_edges = ec_set[p] > 256 ? 256 : ec_set[p];
			gap_pct    = (p % 2) ? 0 : 40;
			stall_pct  = (p == 4) ? 0 : 25;
			// only route over entries that were loaded
			for (k = sb.loaded_prefix(); k < want_edges; k = sb.loaded_prefix())
				push_load(k, rand_node(span), rand_node(span), rand_weight());
			settle();
			apb_write(REG_NODE_COUNT, nc_set[p]);
			apb_write(REG_EDGE_COUNT, ec_set[p]);
			if (p == 3) hold_req = 400;
			for (k = 0; k < 8; k++) begin
				if ($urandom_range(0, 99) < 30)
					push_load($urandom_range(0, 255), rand_node(span), rand_node(span),
						rand_weight());
				else
					push_route(rand_node(span), rand_node(span));
			end
			settle();
		end

		repeat (50) @(posedge clk);
		$display("covered %0d edge loads and %0d route queries over 9 count settings",
			sb.n_loads, sb.n_routes);
		$display("%0d path transactions checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.path_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
